// ===== design/ccmt_pkg.sv =====
// Package for the coastline contour marker: register indexes, field widths, shared types.
// No dependencies.
package ccmt_pkg;
	localparam int MaxWidthDef  = 512;
	localparam int MaxHeightDef = 512;
	localparam int AddrW = 5;

	typedef enum logic [2:0] {
		REG_SEA        = 3'd0,
		REG_LAND       = 3'd1,
		REG_MARK_SEA   = 3'd2,
		REG_MARK_LAND  = 3'd3,
		REG_MARK_CSEA  = 3'd4,
		REG_MARK_CLAND = 3'd5,
		REG_THICK      = 3'd6,
		REG_WIDTH      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] sea;
		logic [7:0] land;
		logic [7:0] coast_sea;
		logic [7:0] coast_land;
		logic [7:0] mark_csea;
		logic [7:0] mark_cland;
		logic [7:0] thick;
		logic [9:0] width;
	} cfg_t;

	// Datapath memory commands issued by the controller.
	typedef enum logic [1:0] {
		MEM_IDLE  = 2'd0,
		MEM_READ  = 2'd1,
		MEM_WRITE = 2'd2
	} mem_op_t;
endpackage

// ===== design/ccmt_if.sv =====
// Valid/ready channel interfaces for load/read items and for result items.
// Depends on nothing.
interface ccmt_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] pixel_value;
	logic       cloudy;
	logic       last_pixel;
	modport source (output valid, operation, pixel_value, cloudy, last_pixel, input ready);
	modport sink (input valid, operation, pixel_value, cloudy, last_pixel, output ready);
endinterface

interface ccmt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] marked_pixel;
	logic       last_of_image;
	modport source (output valid, marked_pixel, last_of_image, input ready);
	modport sink (input valid, marked_pixel, last_of_image, output ready);
endinterface

// ===== design/ccmt_regs.sv =====
// APB-style configuration register file for the contour marker.
// Depends on ccmt_pkg.
module ccmt_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ccmt_pkg::AddrW-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output ccmt_pkg::cfg_t        cfg
);
	import ccmt_pkg::*;
	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr;

	assign idx = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{sea: 8'd0, land: 8'd1, coast_sea: 8'd2, coast_land: 8'd3,
				mark_csea: 8'd4, mark_cland: 8'd5, thick: 8'd1, width: 10'd512};
		end else if (wr) begin
			case (idx)
				REG_SEA:        cfg_q.sea <= pwdata[7:0];
				REG_LAND:       cfg_q.land <= pwdata[7:0];
				REG_MARK_SEA:   cfg_q.coast_sea <= pwdata[7:0];
				REG_MARK_LAND:  cfg_q.coast_land <= pwdata[7:0];
				REG_MARK_CSEA:  cfg_q.mark_csea <= pwdata[7:0];
				REG_MARK_CLAND: cfg_q.mark_cland <= pwdata[7:0];
				REG_THICK:      cfg_q.thick <= pwdata[7:0];
				REG_WIDTH:      cfg_q.width <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_SEA:        prdata[7:0] = cfg_q.sea;
			REG_LAND:       prdata[7:0] = cfg_q.land;
			REG_MARK_SEA:   prdata[7:0] = cfg_q.coast_sea;
			REG_MARK_LAND:  prdata[7:0] = cfg_q.coast_land;
			REG_MARK_CSEA:  prdata[7:0] = cfg_q.mark_csea;
			REG_MARK_CLAND: prdata[7:0] = cfg_q.mark_cland;
			REG_THICK:      prdata[7:0] = cfg_q.thick;
			REG_WIDTH:      prdata[9:0] = cfg_q.width;
			default:        prdata = '0;
		endcase
		if (paddr[1:0] != 2'b00) prdata = '0;
	end
endmodule

// ===== design/ccmt_datapath.sv =====
// Datapath: pixel and cloud memories with one read/write port and a registered read.
// Depends on ccmt_pkg.
module ccmt_datapath #(
	parameter int Depth = ccmt_pkg::MaxWidthDef * ccmt_pkg::MaxHeightDef,
	parameter int AW = $clog2(Depth)
) (
	input  logic                 clk,
	input  ccmt_pkg::mem_op_t    op,
	input  logic [AW-1:0]        addr,
	input  logic [7:0]           wdata,
	input  logic                 wcloud,
	output logic [7:0]           rdata,
	output logic                 rcloud
);
	import ccmt_pkg::*;
	logic [7:0] pix_mem [Depth];
	logic       cld_mem [Depth];

	always_ff @(posedge clk) begin
		if (op == MEM_WRITE) begin
			pix_mem[addr] <= wdata;
		end
		if (op == MEM_READ) begin
			rdata <= pix_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (op == MEM_WRITE) begin
			cld_mem[addr] <= wcloud;
		end
		if (op == MEM_READ) begin
			rcloud <= cld_mem[addr];
		end
	end
endmodule

// ===== design/ccmt_ctrl.sv =====
// Controller: loading, contour passes over the memory and read-out sequencing.
// Depends on ccmt_pkg; drives ccmt_datapath through memory commands.
module ccmt_ctrl #(
	parameter int MaxWidth = ccmt_pkg::MaxWidthDef,
	parameter int MaxHeight = ccmt_pkg::MaxHeightDef,
	parameter int Depth = MaxWidth * MaxHeight,
	parameter int AW = $clog2(Depth),
	parameter int CW = $clog2(Depth + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ccmt_pkg::cfg_t    cfg,
	ccmt_in_if.sink           in_ch,
	ccmt_out_if.source        out_ch,
	output ccmt_pkg::mem_op_t op,
	output logic [AW-1:0]     addr,
	output logic [7:0]        wdata,
	output logic              wcloud,
	input  logic [7:0]        rdata,
	input  logic              rcloud
);
	import ccmt_pkg::*;

	typedef enum logic [3:0] {
		S_LOAD, S_DIV, S_LINE, S_FETCH, S_EVAL, S_MREQ, S_MCHK, S_NEXT, S_NXRD, S_NXEV,
		S_READ, S_RWAIT, S_OUT
	} state_t;

	state_t          state_q;
	logic            reading_q;
	logic [CW-1:0]   count_q, rptr_q;
	logic [CW-1:0]   h_q, rem_q;
	logic [9:0]      w_q;
	logic [7:0]      t_q;
	logic            col_q;
	logic [CW-1:0]   line_q, n_q, j_q, stride_q, base_q;
	logic            flag_q, ent_q;
	logic [8:0]      ig_q;
	logic            side_q;
	logic [CW-1:0]   pos_q;
	logic            last_q;
	logic [7:0]      opix_q;

	logic [CW-1:0] nlines, prod;
	logic          is_land, is_sea, tgt_ok, want, eff_flag;

	assign nlines = col_q ? CW'(w_q) : h_q;
	assign is_land = (rdata == cfg.land) || (col_q && rdata == cfg.coast_land);
	assign is_sea = (rdata == cfg.sea) || (col_q && rdata == cfg.coast_sea);
	// The first pixel of a line sets the land flag without counting as a transition.
	assign eff_flag = flag_q || (j_q == '0 && is_land);
	assign tgt_ok = side_q ? ((CW+1)'(ig_q) + (CW+1)'(1) <= (CW+1)'(j_q))
		: ((CW+1)'(j_q) + (CW+1)'(ig_q) < (CW+1)'(n_q));
	assign want = (side_q ? ~ent_q : ent_q);
	assign prod = pos_q * stride_q;

	assign in_ch.ready = (state_q == S_LOAD);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.marked_pixel = opix_q;
	assign out_ch.last_of_image = last_q;

	always_comb begin
		op = MEM_IDLE;
		addr = AW'(base_q + prod);
		wdata = want ? (rcloud ? cfg.mark_cland : cfg.coast_land)
			: (rcloud ? cfg.mark_csea : cfg.coast_sea);
		wcloud = rcloud;
		case (state_q)
			S_LOAD: begin
				if (in_ch.valid && !in_ch.operation && (reading_q || count_q < CW'(Depth))) begin
					op = MEM_WRITE;
					addr = reading_q ? '0 : AW'(count_q);
					wdata = in_ch.pixel_value;
					wcloud = in_ch.cloudy;
				end else if (in_ch.valid && in_ch.operation && reading_q && rptr_q < count_q) begin
					op = MEM_READ;
					addr = AW'(rptr_q);
				end
			end
			S_FETCH, S_MREQ, S_NXRD: op = MEM_READ;
			// Only a target that was just read may be written; skipped targets pass here too.
			S_MCHK: if (tgt_ok && rdata == (want ? cfg.land : cfg.sea)) op = MEM_WRITE;
			default: op = MEM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			reading_q <= 1'b0;
			count_q <= '0;
			rptr_q <= '0;
			h_q <= '0; rem_q <= '0; w_q <= '0; t_q <= '0; col_q <= 1'b0;
			line_q <= '0; n_q <= '0; j_q <= '0; stride_q <= '0; base_q <= '0;
			flag_q <= 1'b0; ent_q <= 1'b0; ig_q <= '0; side_q <= 1'b0; pos_q <= '0;
			last_q <= 1'b0; opix_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_ch.valid && !in_ch.operation) begin
						logic [CW-1:0] c;
						c = reading_q ? '0 : count_q;
						if (c < CW'(Depth)) c = c + CW'(1);
						count_q <= c;
						reading_q <= 1'b0;
						rptr_q <= '0;
						if (in_ch.last_pixel) begin
							w_q <= (cfg.width == '0) ? 10'd1 : cfg.width;
							t_q <= (cfg.thick == '0) ? 8'd1 : cfg.thick;
							h_q <= '0;
							rem_q <= c;
							state_q <= S_DIV;
						end
					end else if (in_ch.valid && reading_q && rptr_q < count_q) begin
						last_q <= (rptr_q + CW'(1) == count_q);
						state_q <= S_RWAIT;
					end
				end
				// Height by repeated subtraction of the width, one row per cycle.
				S_DIV: begin
					if (rem_q >= CW'(w_q)) begin
						rem_q <= rem_q - CW'(w_q);
						h_q <= h_q + CW'(1);
					end else begin
						col_q <= 1'b0;
						line_q <= '0;
						state_q <= S_LINE;
					end
				end
				S_LINE: begin
					if (line_q >= nlines) begin
						if (!col_q && h_q != '0) begin
							col_q <= 1'b1;
							line_q <= '0;
						end else begin
							reading_q <= 1'b1;
							rptr_q <= '0;
							state_q <= S_LOAD;
						end
					end else begin
						base_q <= col_q ? line_q : CW'(line_q * CW'(w_q));
						stride_q <= col_q ? CW'(w_q) : CW'(1);
						n_q <= col_q ? h_q : CW'(w_q);
						j_q <= '0;
						pos_q <= '0;
						flag_q <= 1'b0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_EVAL;
				S_EVAL: begin
					if (!eff_flag && is_land) begin
						ent_q <= 1'b1; ig_q <= '0; side_q <= 1'b0; pos_q <= j_q;
						state_q <= S_MREQ;
					end else if (eff_flag && is_sea) begin
						ent_q <= 1'b0; ig_q <= '0; side_q <= 1'b0; pos_q <= j_q;
						state_q <= S_MREQ;
					end else begin
						flag_q <= eff_flag;
						if (j_q + CW'(1) >= n_q) begin
							line_q <= line_q + CW'(1);
							state_q <= S_LINE;
						end else begin
							j_q <= j_q + CW'(1);
							pos_q <= j_q + CW'(1);
							state_q <= S_FETCH;
						end
					end
				end
				S_MREQ: state_q <= S_MCHK;
				S_MCHK: begin
					logic [8:0] ni;
					logic       ns;
					ns = ~side_q;
					ni = side_q ? ig_q + 9'd1 : ig_q;
					side_q <= ns;
					ig_q <= ni;
					if (side_q && ni >= {1'b0, t_q}) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_MCHK;
						// Compute next target position and skip out-of-range ones.
						if (ns ? ((CW+1)'(ni) + (CW+1)'(1) <= (CW+1)'(j_q))
							: ((CW+1)'(j_q) + (CW+1)'(ni) < (CW+1)'(n_q))) begin
							pos_q <= ns ? (j_q - CW'(ni) - CW'(1)) : (j_q + CW'(ni));
							state_q <= S_MREQ;
						end
					end
				end
				S_NEXT: begin
					logic [CW:0] nj;
					nj = (CW+1)'(j_q) + (CW+1)'(t_q) - (CW+1)'(1);
					if (nj + (CW+1)'(1) >= (CW+1)'(n_q)) begin
						line_q <= line_q + CW'(1);
						state_q <= S_LINE;
					end else begin
						j_q <= CW'(nj);
						pos_q <= CW'(nj + (CW+1)'(1));
						state_q <= S_NXRD;
					end
				end
				S_NXRD: state_q <= S_NXEV;
				S_NXEV: begin
					flag_q <= is_land;
					j_q <= j_q + CW'(1);
					pos_q <= j_q + CW'(1);
					state_q <= S_FETCH;
				end
				S_RWAIT: begin
					opix_q <= rdata;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) begin
						if (last_q) begin
							reading_q <= 1'b0;
							count_q <= '0;
							rptr_q <= '0;
						end else begin
							rptr_q <= rptr_q + CW'(1);
						end
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

// ===== design/coastline_contour_marker_thick_core.sv =====
// Coastline contour marker, top level. Loads follow back to back.
// A read passes the memory read, the output register and the result transfer; its result
// is held in the read data and output registers, and the input waits until the transfer.
// After the last load the height is found by subtracting the width row by row, then a
// row pass and a column pass go line by line: they visit pixels, check neighbors, skip
// those out of range and reload the flag. arst_n clears control state; memories are not reset.
module coastline_contour_marker_thick_core #(
	parameter int MaxWidth = ccmt_pkg::MaxWidthDef,
	parameter int MaxHeight = ccmt_pkg::MaxHeightDef
) (
	input  logic clk,
	input  logic arst_n,
	ccmt_in_if.sink    in_ch,
	ccmt_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ccmt_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ccmt_pkg::*;
	localparam int Depth = MaxWidth * MaxHeight;
	localparam int AW = $clog2(Depth);

	cfg_t cfg;
	mem_op_t op;
	logic [AW-1:0] addr;
	logic [7:0] wdata, rdata;
	logic wcloud, rcloud;

	// Register file sits beside the engine; the user must write it only while idle (not enforced here).
	ccmt_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	// The controller sequences every memory transfer of loading, marking and reading.
	ccmt_ctrl #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_ctrl (
		.clk, .arst_n, .cfg, .in_ch, .out_ch, .op, .addr, .wdata, .wcloud,
		.rdata, .rcloud);

	// Pixel and cloud stores.
	ccmt_datapath #(.Depth(Depth)) u_dp (.clk, .op, .addr, .wdata, .wcloud,
		.rdata, .rcloud);
endmodule
